### sv/yrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_pkg
// shared types, format codes and helpers for the yuv422/rgb565 to rgb24 core
// ----------------------------------------------------------------------------
package yrc_pkg;

	// source format codes
	localparam logic [1:0] FMT_YUYV   = 2'd0;
	localparam logic [1:0] FMT_YVYU   = 2'd1;
	localparam logic [1:0] FMT_UYVY   = 2'd2;
	localparam logic [1:0] FMT_RGB565 = 2'd3;

	// chroma midpoint
	localparam logic [7:0] CHROMA_MID = 8'h80;

	typedef logic [1:0] fmt_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb24_t;

	typedef struct packed {
		rgb24_t first;
		rgb24_t second;
	} pix_pair_t;

	// saturate a small signed sum to 0..255
	function automatic logic [7:0] clamp8(input logic signed [11:0] x);
		logic [7:0] res;
		if (x[11]) begin
			res = 8'd0;
		end else if (x[10:8] != 3'd0) begin
			res = 8'hFF;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

	// widen one little-endian rgb565 pixel, zero low bits
	function automatic rgb24_t expand565(input logic [15:0] w);
		rgb24_t p;
		p.red   = {w[15:11], 3'b000};
		p.green = {w[10:5], 2'b00};
		p.blue  = {w[4:0], 3'b000};
		return p;
	endfunction

endpackage

### sv/yrc_pixel_cvt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrc_pixel_cvt
// combinational conversion of one four-byte word into two rgb24 pixels
// ----------------------------------------------------------------------------
module yrc_pixel_cvt (
	input  yrc_pkg::fmt_t      fmt,
	input  logic [7:0]         b0,
	input  logic [7:0]         b1,
	input  logic [7:0]         b2,
	input  logic [7:0]         b3,
	input  logic               second_present,
	output yrc_pkg::pix_pair_t pix
);

	logic [7:0]         y0;
	logic [7:0]         y1;
	logic [7:0]         u;
	logic [7:0]         v;
	logic signed [7:0]  du;
	logic signed [7:0]  dv;
	logic signed [11:0] du12;
	logic signed [11:0] dv12;
	logic signed [15:0] du16;
	logic signed [11:0] r_sum;
	logic signed [11:0] g_sum;
	logic signed [15:0] b_prod;
	logic signed [15:0] b_shr;
	logic signed [11:0] r_off;
	logic signed [11:0] g_off;
	logic signed [11:0] b_off;
	logic signed [11:0] y0_12;
	logic signed [11:0] y1_12;
	yrc_pkg::rgb24_t    yuv_first;
	yrc_pkg::rgb24_t    yuv_second;
	yrc_pkg::rgb24_t    second_px;

	// byte lane selection per packing
	always_comb begin
		unique case (fmt)
			yrc_pkg::FMT_YVYU: begin
				y0 = b0; v = b1; y1 = b2; u = b3;
			end
			yrc_pkg::FMT_UYVY: begin
				u = b0; y0 = b1; v = b2; y1 = b3;
			end
			default: begin
				y0 = b0; u = b1; y1 = b2; v = b3;
			end
		endcase
	end

	// u - 128 is the msb flipped, read as signed
	assign du   = $signed(u ^ yrc_pkg::CHROMA_MID);
	assign dv   = $signed(v ^ yrc_pkg::CHROMA_MID);
	assign du12 = {{4{du[7]}}, du};
	assign dv12 = {{4{dv[7]}}, dv};
	assign du16 = {{8{du[7]}}, du};

	// shared chroma offsets, arithmetic shifts floor
	assign r_sum  = dv12 + (dv12 <<< 1);
	assign r_off  = r_sum >>> 1;
	assign g_sum  = du12 + (du12 <<< 1) + (dv12 <<< 1) + (dv12 <<< 2);
	assign g_off  = g_sum >>> 3;
	assign b_prod = (du16 <<< 7) + du16;
	assign b_shr  = b_prod >>> 6;
	assign b_off  = b_shr[11:0];

	assign y0_12 = $signed({4'b0000, y0});
	assign y1_12 = $signed({4'b0000, y1});

	always_comb begin
		yuv_first.red    = yrc_pkg::clamp8(y0_12 + r_off);
		yuv_first.green  = yrc_pkg::clamp8(y0_12 - g_off);
		yuv_first.blue   = yrc_pkg::clamp8(y0_12 + b_off);
		yuv_second.red   = yrc_pkg::clamp8(y1_12 + r_off);
		yuv_second.green = yrc_pkg::clamp8(y1_12 - g_off);
		yuv_second.blue  = yrc_pkg::clamp8(y1_12 + b_off);
	end

	always_comb begin
		if (fmt == yrc_pkg::FMT_RGB565) begin
			pix.first = yrc_pkg::expand565({b1, b0});
			second_px = yrc_pkg::expand565({b3, b2});
		end else begin
			pix.first = yuv_first;
			second_px = yuv_second;
		end
		// lone trailing pixel reads as black
		pix.second = second_present ? second_px : '0;
	end

endmodule

### sv/yuv422_rgb565_to_rgb24_core.sv
`timescale 1ns / 1ps
// pipeline: a request is captured in stage 1, passes the conversion logic and is
//   held in the result register, which drives done and the result ports
// throughput: one request per cycle; busy is tied low, and a single
//   conversion stage sits between the input and result registers
// reset: arst_n clears pipeline valids, done and source_format (to yuyv)
// the receiver cannot stall: every result is shown for exactly one cycle
// ----------------------------------------------------------------------------
// yuv422_rgb565_to_rgb24_core
// two-pixel color converter: packed yuv 4:2:2 (yuyv, yvyu, uyvy) or two
// little-endian rgb565 pixels in, two rgb24 pixels out per word
// ----------------------------------------------------------------------------
module yuv422_rgb565_to_rgb24_core (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	// request side
	input  logic       start,
	output logic       busy,
	input  logic [7:0] byte0,
	input  logic [7:0] byte1,
	input  logic [7:0] byte2,
	input  logic [7:0] byte3,
	input  logic       second_present,
	input  logic       frame_end,
	// result side
	output logic       done,
	output logic [7:0] red_first,
	output logic [7:0] green_first,
	output logic [7:0] blue_first,
	output logic [7:0] red_second,
	output logic [7:0] green_second,
	output logic [7:0] blue_second,
	output logic       second_valid,
	output logic       frame_last
);

	// format register; the user must write it only while the core is idle (not enforced)
	yrc_pkg::fmt_t      source_format_q;

	// stage 1: captured request word
	logic               valid_s1;
	logic [7:0]         b0_s1;
	logic [7:0]         b1_s1;
	logic [7:0]         b2_s1;
	logic [7:0]         b3_s1;
	logic               second_s1;
	logic               frame_end_s1;

	// stage 2: result register
	logic               valid_s2;
	yrc_pkg::pix_pair_t pix_s2;
	logic               second_s2;
	logic               frame_end_s2;

	yrc_pkg::pix_pair_t pix_cvt;

	// never stalls: the pipeline advances every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= yrc_pkg::FMT_YUYV;
		end else if (cfg_we) begin
			source_format_q <= cfg_wdata;
		end
	end

	// request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			b0_s1        <= byte0;
			b1_s1        <= byte1;
			b2_s1        <= byte2;
			b3_s1        <= byte3;
			second_s1    <= second_present;
			frame_end_s1 <= frame_end;
		end
	end

	// color math sits between the two registers
	yrc_pixel_cvt u_cvt (
		.fmt            (source_format_q),
		.b0             (b0_s1),
		.b1             (b1_s1),
		.b2             (b2_s1),
		.b3             (b3_s1),
		.second_present (second_s1),
		.pix            (pix_cvt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			pix_s2       <= pix_cvt;
			second_s2    <= second_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// result ports
	assign done         = valid_s2;
	assign red_first    = pix_s2.first.red;
	assign green_first  = pix_s2.first.green;
	assign blue_first   = pix_s2.first.blue;
	assign red_second   = pix_s2.second.red;
	assign green_second = pix_s2.second.green;
	assign blue_second  = pix_s2.second.blue;
	assign second_valid = second_s2;
	assign frame_last   = frame_end_s2;

	// every request yields a strobe after passing the stage 1 and result registers
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("request did not produce a result strobe");

	// no strobe unless stage 1 held a captured request
	a_done_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("result strobe without a captured request");

	// frame marker travels with its word
	a_frame_mark: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 (frame_last == $past(frame_end, 2)))
		else $error("frame_last does not match its request");

	// lone trailing pixel is black
	a_lone_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !second_valid) |->
			(red_second == 8'd0 && green_second == 8'd0 && blue_second == 8'd0))
		else $error("invalid second pixel is not zero");

endmodule
